// File: rtl/mfps_pkg.sv
// ----------------------------------------------------------------------------
// mfps_pkg
// Shared types, constants and the saturating path-sum adder for the minimum
// falling path sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package mfps_pkg;

    localparam int VALUE_W = 16;
    localparam int SUM_W   = 32;
    localparam int WIDTH_W = 11;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [WIDTH_W-1:0]        row_width_t;

    localparam row_width_t ROW_WIDTH_RESET = 11'd1024;
    localparam sum_t       SUM_MAX         = 32'sh7FFF_FFFF;
    localparam sum_t       SUM_MIN         = 32'sh8000_0000;

    // Per-element control handed from the column tracker to the path unit
    typedef struct packed {
        logic first_row;   // element belongs to the first row of the matrix
        logic has_left;    // an upper-left neighbor exists
        logic has_right;   // an upper-right neighbor exists
        logic row_start;   // element opens a new row
        logic last;        // final element of the matrix
    } stage_flags_t;

    // Add an element to a path sum, clamping to the signed 32-bit range
    function automatic sum_t sat_add(value_t a, sum_t b);
        logic signed [SUM_W:0] s;
        begin
            s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
            if (s[SUM_W] != s[SUM_W-1])
            begin
                sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                sat_add = s[SUM_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/mfps_if.sv
// ----------------------------------------------------------------------------
// mfps_if
// Valid/ready channels of the minimum falling path sum block: element input,
// result output and row width configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfps_in_if;
    logic                valid;
    logic                ready;
    mfps_pkg::value_t    value;
    logic                last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface mfps_out_if;
    logic                valid;
    logic                ready;
    mfps_pkg::sum_t      min_path_sum;

    modport source (output valid, output min_path_sum, input ready);
    modport sink   (input valid, input min_path_sum, output ready);
endinterface

interface mfps_cfg_if;
    logic                  valid;
    logic                  ready;
    mfps_pkg::row_width_t  row_width;

    modport source (output valid, output row_width, input ready);
    modport sink   (input valid, input row_width, output ready);
endinterface

`default_nettype wire

// File: rtl/mfps_row_mem.sv
// ----------------------------------------------------------------------------
// mfps_row_mem
// Row buffer of path sums: one write port, two registered read ports, with
// bypass of a write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_row_mem #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire mfps_pkg::sum_t       wr_data,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr0,
    input  wire logic [IDX_W-1:0]     rd_addr1,
    output mfps_pkg::sum_t            rd_data0,
    output mfps_pkg::sum_t            rd_data1
);

    mfps_pkg::sum_t mem [DEPTH];

    mfps_pkg::sum_t rd0_reg;
    mfps_pkg::sum_t rd1_reg;
    mfps_pkg::sum_t byp_data_reg;
    logic           byp0_reg;
    logic           byp1_reg;

    // Write the path sum of the element leaving the compute stage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read both neighbors and capture a concurrent write for bypass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg      <= mem[rd_addr0];
            rd1_reg      <= mem[rd_addr1];
            byp_data_reg <= wr_data;
        end
    end

    // Track whether the concurrent write hit a read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp0_reg <= 1'b0;
            byp1_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp0_reg <= wr_en && (wr_addr == rd_addr0);
            byp1_reg <= wr_en && (wr_addr == rd_addr1);
        end
    end

    assign rd_data0 = byp0_reg ? byp_data_reg : rd0_reg;
    assign rd_data1 = byp1_reg ? byp_data_reg : rd1_reg;

endmodule

`default_nettype wire

// File: rtl/mfps_col_ctrl.sv
// ----------------------------------------------------------------------------
// mfps_col_ctrl
// Input stage: tracks the column and first-row state, issues row buffer
// reads for the upper and upper-right neighbors and loads the compute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_col_ctrl #(
    parameter int MAX_COLS = 1024,
    parameter int IDX_W    = 10,
    parameter int CNT_W    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    mfps_in_if.sink                        item,
    input  wire mfps_pkg::row_width_t      row_width,
    input  wire logic                      s1_adv,
    output logic                           rd_en,
    output logic [IDX_W-1:0]               rd_addr0,
    output logic [IDX_W-1:0]               rd_addr1,
    output logic                           s1_valid,
    output mfps_pkg::stage_flags_t         s1_flags,
    output logic [IDX_W-1:0]               s1_col,
    output mfps_pkg::value_t               s1_value
);

    logic [IDX_W-1:0]        col_reg;
    logic [IDX_W-1:0]        col_next;
    logic                    first_reg;
    logic                    first_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    mfps_pkg::stage_flags_t  s1_flags_reg;
    logic [IDX_W-1:0]        s1_col_reg;
    mfps_pkg::value_t        s1_value_reg;

    logic [31:0]             rw_ext;
    logic [31:0]             w_clamp;
    logic [CNT_W-1:0]        w_eff;
    logic [CNT_W-1:0]        col_ext;
    logic                    wrap;
    logic [IDX_W-1:0]        col;
    logic                    first;
    logic [CNT_W-1:0]        col_plus;
    logic                    has_right;
    logic                    accept;
    mfps_pkg::stage_flags_t  flags;

    // Clamp the row width to 1..MAX_COLS
    always_comb
    begin
        rw_ext = 32'(row_width);
        if (rw_ext == 32'd0)
        begin
            w_clamp = 32'd1;
        end
        else if (rw_ext > 32'(MAX_COLS))
        begin
            w_clamp = 32'(MAX_COLS);
        end
        else
        begin
            w_clamp = rw_ext;
        end
        w_eff = w_clamp[CNT_W-1:0];
    end

    // Resolve the column of this element; a narrowed width closes the row
    always_comb
    begin
        col_ext   = CNT_W'(col_reg);
        wrap      = (col_ext >= w_eff);
        col       = wrap ? '0 : col_reg;
        first     = wrap ? 1'b0 : first_reg;
        col_plus  = CNT_W'(col) + CNT_W'(1);
        has_right = (col_plus < w_eff);

        flags.first_row = first;
        flags.has_left  = (col != '0);
        flags.has_right = has_right;
        flags.row_start = (col == '0);
        flags.last      = item.last_item;
    end

    assign accept     = item.valid && item.ready;
    assign item.ready = !s1_valid_reg || s1_adv;

    // Read upper and upper-right sums of the previous row
    assign rd_en    = accept;
    assign rd_addr0 = col;
    assign rd_addr1 = has_right ? col_plus[IDX_W-1:0] : col;

    // Advance the column; restart on row end and on the final element
    always_comb
    begin
        if (item.last_item)
        begin
            col_next   = '0;
            first_next = 1'b1;
        end
        else if (!has_right)
        begin
            col_next   = '0;
            first_next = 1'b0;
        end
        else
        begin
            col_next   = col_plus[IDX_W-1:0];
            first_next = first;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Hold column state and compute stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            first_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg   <= col_next;
                first_reg <= first_next;
            end
        end
    end

    // Load the element into the compute stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
            s1_col_reg   <= col;
            s1_value_reg <= item.value;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_flags = s1_flags_reg;
    assign s1_col   = s1_col_reg;
    assign s1_value = s1_value_reg;

endmodule

`default_nettype wire

// File: rtl/mfps_path_unit.sv
// ----------------------------------------------------------------------------
// mfps_path_unit
// Compute stage: picks the smallest neighbor sum, adds the element with
// saturation, tracks the row minimum and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_path_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s1_valid,
    input  wire mfps_pkg::stage_flags_t    s1_flags,
    input  wire mfps_pkg::value_t          s1_value,
    input  wire mfps_pkg::sum_t            up_sum,
    input  wire mfps_pkg::sum_t            right_sum,
    output logic                           s1_adv,
    output logic                           wr_en,
    output mfps_pkg::sum_t                 wr_data,
    mfps_out_if.source                     result
);

    mfps_pkg::sum_t saved_left_reg;
    mfps_pkg::sum_t row_min_reg;
    mfps_pkg::sum_t row_min_next;
    logic           out_valid_reg;
    mfps_pkg::sum_t out_sum_reg;

    mfps_pkg::sum_t best;
    mfps_pkg::sum_t sum;
    mfps_pkg::sum_t min_base;
    logic           fire;

    // Select the smallest existing neighbor and form the path sum
    always_comb
    begin
        best = up_sum;
        if (s1_flags.has_left && (saved_left_reg < best))
        begin
            best = saved_left_reg;
        end
        if (s1_flags.has_right && (right_sum < best))
        begin
            best = right_sum;
        end
        if (s1_flags.first_row)
        begin
            sum = mfps_pkg::SUM_W'(s1_value);
        end
        else
        begin
            sum = mfps_pkg::sat_add(s1_value, best);
        end
    end

    // Fold the sum into the running row minimum
    always_comb
    begin
        min_base     = s1_flags.row_start ? mfps_pkg::SUM_MAX : row_min_reg;
        row_min_next = (sum < min_base) ? sum : min_base;
    end

    // Stall only a final element that finds the result register occupied
    assign s1_adv  = !s1_flags.last || !out_valid_reg || result.ready;
    assign fire    = s1_valid && s1_adv;
    assign wr_en   = fire;
    assign wr_data = sum;

    // Hold left neighbor, row minimum and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_left_reg <= '0;
            row_min_reg    <= mfps_pkg::SUM_MAX;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                saved_left_reg <= up_sum;
                row_min_reg    <= row_min_next;
            end
            if (fire && s1_flags.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the minimum path sum of the final row
    always_ff @(posedge clk)
    begin
        if (fire && s1_flags.last)
        begin
            out_sum_reg <= row_min_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.min_path_sum = out_sum_reg;

endmodule

`default_nettype wire

// File: rtl/min_falling_path_sum.sv
// ----------------------------------------------------------------------------
// min_falling_path_sum
// Streaming minimum falling path sum over a signed matrix in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one 16-bit signed element per transaction, last_item marks the
//            final element of the matrix.
//   cfg    : write transaction loads row_width (columns per row); always
//            ready, write only while no element is in flight.
//   result : one 32-bit signed minimum path sum per matrix, after the final
//            element.
// Throughput: one element per cycle unless a final element is stalled. The
//   row buffer is read at acceptance on two ports (upper and upper-right
//   sums) and the sum is formed and written back from the compute stage,
//   with bypass when the write and a read hit the same column.
// Result: taken final element -> compute stage -> result register.
// Reset: column, first-row flag, row minimum and left neighbor return to
//   their start values and the row width to 1024; the row buffer is not
//   cleared, since the first row of each matrix overwrites it.
// Stall: the result register holds while result.ready is low; item.ready
//   drops only when a final element is waiting for that register.
// ----------------------------------------------------------------------------
`default_nettype none

module min_falling_path_sum #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mfps_in_if.sink         item,
    mfps_out_if.source      result,
    mfps_cfg_if.sink        cfg
);

    localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);

    mfps_pkg::row_width_t    row_width_reg;
    logic                    s1_adv;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr0;
    logic [IDX_W-1:0]        rd_addr1;
    logic                    s1_valid;
    mfps_pkg::stage_flags_t  s1_flags;
    logic [IDX_W-1:0]        s1_col;
    mfps_pkg::value_t        s1_value;
    mfps_pkg::sum_t          up_sum;
    mfps_pkg::sum_t          right_sum;
    logic                    wr_en;
    mfps_pkg::sum_t          wr_data;

    // Hold the row width register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= mfps_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            row_width_reg <= cfg.row_width;
        end
    end

    mfps_col_ctrl #(
        .MAX_COLS (MAX_COLS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_col_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .row_width (row_width_reg),
        .s1_adv    (s1_adv),
        .rd_en     (rd_en),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .s1_valid  (s1_valid),
        .s1_flags  (s1_flags),
        .s1_col    (s1_col),
        .s1_value  (s1_value)
    );

    mfps_row_mem #(
        .DEPTH (MAX_COLS),
        .IDX_W (IDX_W)
    ) u_row_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (s1_col),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (up_sum),
        .rd_data1 (right_sum)
    );

    mfps_path_unit u_path_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_flags  (s1_flags),
        .s1_value  (s1_value),
        .up_sum    (up_sum),
        .right_sum (right_sum),
        .s1_adv    (s1_adv),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: rtl/mfps_checker.sv
// ----------------------------------------------------------------------------
// mfps_checker
// Port-level checks of the minimum falling path sum block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic             in_last,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire mfps_pkg::sum_t   out_sum
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sum))
        else $error("result changed while stalled");

    // A fresh result must follow an accepted final element
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("result without a final element");

    // Back-pressure only comes from a held result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind min_falling_path_sum mfps_checker u_mfps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_last   (item.last_item),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_sum   (result.min_path_sum)
);

`default_nettype wire
